// ===== hw/rtl/des_block_encrypt_unit_assert.svh =====
// Assertion macros for the DES encrypt unit.
// Used by the top level; no other dependencies.
`ifndef DES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define DES_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DES_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DES_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DES_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define DES_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/des_pkg.sv =====
// Constants, tables and helper functions for the DES encrypt unit.
// No dependencies; used by the round module and the top level.
package des_pkg;
  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned SubW   = 48;
  localparam int unsigned CdW    = 28;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0]  half_t;
  typedef logic [SubW-1:0]   subkey_t;
  typedef logic [CdW-1:0]    cd_t;

  typedef struct packed {
    half_t l;
    half_t r;
    cd_t   c;
    cd_t   d;
  } round_state_t;

  localparam byte unsigned TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned TAB_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam byte unsigned TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam byte unsigned TAB_PC1 [56] = '{
    57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3, 60,52,44,36,
    63,55,47,39,31,23,15,7, 62,54,46,38,30,22,14,6,
    61,53,45,37,29,21,13,5, 28,20,12,4};
  localparam byte unsigned TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam byte unsigned TAB_SHIFT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam byte unsigned TAB_SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Table bit 1 is the MSB of the source word.
  function automatic block_t ip_perm(block_t v);
    block_t res;
    for (int k = 0; k < 64; k++) res[63-k] = v[64-TAB_IP[k]];
    return res;
  endfunction

  function automatic block_t fp_perm(block_t v);
    block_t res;
    for (int k = 0; k < 64; k++) res[63-k] = v[64-TAB_FP[k]];
    return res;
  endfunction

  function automatic logic [55:0] pc1_perm(block_t v);
    logic [55:0] res;
    for (int k = 0; k < 56; k++) res[55-k] = v[64-TAB_PC1[k]];
    return res;
  endfunction

  function automatic subkey_t pc2_perm(logic [55:0] v);
    subkey_t res;
    for (int k = 0; k < 48; k++) res[47-k] = v[56-TAB_PC2[k]];
    return res;
  endfunction

  function automatic cd_t rot28(cd_t c, int unsigned s);
    return (s == 1) ? {c[CdW-2:0], c[CdW-1]} : {c[CdW-3:0], c[CdW-1:CdW-2]};
  endfunction

  function automatic half_t feistel(half_t r, subkey_t sub);
    subkey_t x;
    half_t s;
    half_t res;
    logic [5:0] six;
    for (int k = 0; k < 48; k++) x[47-k] = r[32-TAB_E[k]];
    x = x ^ sub;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = 4'(TAB_SBOX[b][{six[5], six[0], six[4:1]}]);
    end
    for (int k = 0; k < 32; k++) res[31-k] = s[32-TAB_P[k]];
    return res;
  endfunction
endpackage

// ===== hw/rtl/des_stream_if.sv =====
// Valid/ready stream channel carrying one 64-bit block.
// Depends on des_pkg.
interface des_stream_if;
  logic            valid;
  logic            ready;
  des_pkg::block_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/des_round.sv =====
// One DES round stage: key rotation, round function, half swap, register.
// Depends on des_pkg.
module des_round #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_in,
  input  des_pkg::round_state_t     st_in,
  output logic                      vld_out,
  output des_pkg::round_state_t     st_out
);
  import des_pkg::*;

  round_state_t st_nxt;
  round_state_t st_r;
  logic         vld_r;

  always_comb begin
    st_nxt.c = rot28(st_in.c, TAB_SHIFT[ROUND_IDX]);
    st_nxt.d = rot28(st_in.d, TAB_SHIFT[ROUND_IDX]);
    st_nxt.l = st_in.r;
    st_nxt.r = st_in.l ^ feistel(st_in.r, pc2_perm({st_nxt.c, st_nxt.d}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
endmodule

// ===== hw/rtl/des_block_encrypt_unit.sv =====
// DES block encryption unit: single DES, one 64-bit block per request.
// Input request on in_ch (valid/ready), result on out_ch, key on cfg_.
// The key register is written when cfg_wr_en is high; write it only when idle.
// Pipeline: an input stage (initial permutation and PC-1), one register
// stage per round (ROUND_COUNT rounds), and an output register after the
// final permutation. Throughput is one block per cycle while the receiver
// does not stall the output.
// All stages advance together when the output register is empty or taken;
// when the receiver stalls the whole pipeline holds, so nothing is lost or
// repeated, and in_ch.ready drops until the output moves again.
// A synchronous low rst_n clears all valid bits and the key to zero.
// The key is sampled at entry and travels in the pipeline with each block.
module des_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  des_stream_if.sink         in_ch,
  des_stream_if.source       out_ch,
  input  logic               cfg_wr_en,
  input  des_pkg::block_t    cfg_wr_data
);
  import des_pkg::*;
  `include "des_block_encrypt_unit_assert.svh"

  block_t       key_r;
  logic         adv;
  logic         in_vld_r;
  round_state_t in_st_r;
  logic         out_vld_r;
  block_t       out_data_r;
  logic         [ROUND_COUNT:0] vld_chain;
  round_state_t st_chain [ROUND_COUNT+1];
  logic [55:0]  k56;

  // Advance when the output slot is empty or being taken.
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign k56          = pc1_perm(key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      key_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r  <= in_ch.valid;
      out_vld_r <= vld_chain[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {in_st_r.l, in_st_r.r} <= ip_perm(in_ch.data);
      in_st_r.c              <= k56[55:28];
      in_st_r.d              <= k56[27:0];
      out_data_r             <= fp_perm({st_chain[ROUND_COUNT].r, st_chain[ROUND_COUNT].l});
    end
  end

  assign vld_chain[0] = in_vld_r;
  assign st_chain[0]  = in_st_r;

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    des_round #(.ROUND_IDX(i)) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .vld_in  (vld_chain[i]),
      .st_in   (st_chain[i]),
      .vld_out (vld_chain[i+1]),
      .st_out  (st_chain[i+1])
    );
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  `DES_ASSERT_CLK(a_hold_on_stall, clk, rst_n,
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data),
    "result changed while stalled")
  `DES_ASSERT_CLK(a_ready_tracks_out, clk, rst_n,
    !in_ch.ready |-> out_ch.valid && !out_ch.ready,
    "input blocked without output stall")
  `DES_ASSERT_CLK(a_stage_feeds_out, clk, rst_n,
    adv && vld_chain[ROUND_COUNT] |=> out_ch.valid,
    "finished block did not reach output")
  `DES_ASSERT_RST(a_reset_clears, clk,
    !rst_n |=> !out_ch.valid && !in_vld_r,
    "valid bits not cleared by reset")
endmodule
